[design/u2dd_pkg.sv]
// shared types, constants and arctangent table for the unicycle to differential drive block
package u2dd_pkg;

	// request payloads
	typedef struct packed {
		logic               action;
		logic signed [23:0] target_x;
		logic signed [23:0] target_y;
		logic signed [23:0] heading_error;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] right_drive;
		logic signed [31:0] left_drive;
	} out_item_t;

	// action codes
	localparam logic ACT_POSITION = 1'b0;
	localparam logic ACT_HEADING  = 1'b1;

	// core pipeline shape and datapath widths
	localparam int CORE_STAGES = 24;
	localparam int GUARD_BITS  = 24;
	localparam int XY_W        = 52;
	localparam int Z_W         = 64;
	localparam int SQ_W        = 48;
	localparam int RT_W        = 49;
	localparam int HD_W        = 28;

	// pi with 60 fraction bits
	localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
	localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;

	// one stage of the core: cordic vector, square root and heading remainder
	typedef struct packed {
		logic                   action;
		logic                   origin;
		logic signed [XY_W-1:0] cx;
		logic signed [XY_W-1:0] cy;
		logic signed [Z_W-1:0]  cz;
		logic [SQ_W-1:0]        sq_rem;
		logic [RT_W-1:0]        sq_root;
		logic [HD_W-1:0]        hd_rem;
	} core_t;

	// one term of the arctangent series, zero once the shift runs past 60
	function automatic logic [63:0] atan_term(input int unsigned i, input int unsigned m);
		if (i * m <= 60) begin
			return ONE_Q60 >> (i * m);
		end
		return 64'd0;
	endfunction

	// atan(2^-i) with 60 fraction bits, truncated series, elaboration use only
	function automatic logic [63:0] atan_q60(input int unsigned i);
		logic [63:0] acc;
		if (i == 0) begin
			return (PI_Q60 + 64'd2) >> 2;
		end
		acc = atan_term(i, 1);
		acc = acc - atan_term(i, 3) / 3;
		acc = acc + atan_term(i, 5) / 5;
		acc = acc - atan_term(i, 7) / 7;
		acc = acc + atan_term(i, 9) / 9;
		acc = acc - atan_term(i, 11) / 11;
		acc = acc + atan_term(i, 13) / 13;
		acc = acc - atan_term(i, 15) / 15;
		acc = acc + atan_term(i, 17) / 17;
		acc = acc - atan_term(i, 19) / 19;
		acc = acc + atan_term(i, 21) / 21;
		acc = acc - atan_term(i, 23) / 23;
		acc = acc + atan_term(i, 25) / 25;
		acc = acc - atan_term(i, 27) / 27;
		acc = acc + atan_term(i, 29) / 29;
		acc = acc - atan_term(i, 31) / 31;
		acc = acc + atan_term(i, 33) / 33;
		acc = acc - atan_term(i, 35) / 35;
		acc = acc + atan_term(i, 37) / 37;
		acc = acc - atan_term(i, 39) / 39;
		acc = acc + atan_term(i, 41) / 41;
		acc = acc - atan_term(i, 43) / 43;
		acc = acc + atan_term(i, 45) / 45;
		acc = acc - atan_term(i, 47) / 47;
		acc = acc + atan_term(i, 49) / 49;
		acc = acc - atan_term(i, 51) / 51;
		acc = acc + atan_term(i, 53) / 53;
		acc = acc - atan_term(i, 55) / 55;
		acc = acc + atan_term(i, 57) / 57;
		acc = acc - atan_term(i, 59) / 59;
		return acc;
	endfunction

endpackage

[design/unicycle_to_differential_drive.sv]
// top level: pipelined unicycle to differential drive command converter
//
// Requests arrive on in_valid/in_ready with an in_item payload: a position error
// (target_x, target_y) or, when action is set, a heading error. Each request gives
// one result on out_valid/out_ready: right and left wheel drives, 8 fraction bits,
// saturated to 32 signed bits. cfg_we/cfg_wdata write turn_gain.
// There are 29 register stages: an input stage (squares, quadrant fold, heading
// offset), a radicand add stage, 24 core stages (one square root digit and one
// modulo step each, plus one CORDIC rotation in each of the first CORDIC_STEPS),
// then angle select, gain multiply and the sum/saturate output register.
// Throughput is one request per cycle while out_ready does not stall the output.
// Every stage has its own valid bit and loads when empty or when its successor
// moves, so bubbles collapse while out_ready is low and in_ready stays high
// until the pipeline is full. Nothing is dropped or repeated under stall.
// Reset clears all valid bits and sets turn_gain to 1500.
module unicycle_to_differential_drive
	import u2dd_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = 16,
	parameter int CORDIC_STEPS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item,
	input  logic        cfg_we,
	input  logic [11:0] cfg_wdata
);

	localparam int F  = ANGLE_FRAC_BITS;
	localparam int S  = F - 7;
	localparam int AW = F + 4;
	localparam int WW = AW + 13;
	localparam int BW = F + 18;
	localparam int SW = F + 20;

	localparam logic [63:0] PI_F_W = (PI_Q60 + (64'd1 << (59 - F))) >> (60 - F);
	localparam logic [63:0] TP_F_W = PI_F_W << 1;
	localparam logic [63:0] HD_OFF_W = TP_F_W * ((64'd8388608 + TP_F_W - 64'd1) / TP_F_W);
	localparam logic [HD_W-1:0] PI_F = PI_F_W[HD_W-1:0];
	localparam logic [HD_W-1:0] TP_F = TP_F_W[HD_W-1:0];
	localparam logic signed [Z_W-1:0] Z_HALF = 64'sd1 <<< (59 - F);
	localparam logic signed [SW-1:0] RND_HALF = {{(SW-1){1'b0}}, 1'b1} << (S - 1);
	localparam logic signed [63:0] DRV_MAX = 64'sd2147483647;
	localparam logic signed [63:0] DRV_MIN = -64'sd2147483648;

	// saturate a drive to 32 signed bits
	function automatic logic [31:0] sat_drive(input logic signed [63:0] v);
		logic [31:0] res;
		res = v[31:0];
		if (v > DRV_MAX) begin
			res = DRV_MAX[31:0];
		end else if (v < DRV_MIN) begin
			res = DRV_MIN[31:0];
		end
		return res;
	endfunction

	// configuration register
	logic [11:0] turn_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_gain_q <= 12'd1500;
		end else if (cfg_we) begin
			turn_gain_q <= cfg_wdata;
		end
	end

	// stage enables and valids
	logic en_s1, en_s2, en_s27, en_s28, en_s29;
	logic vld_s1, vld_s2, vld_s27, vld_s28, vld_s29;
	logic core_en [CORE_STAGES];
	logic core_vld_sk [CORE_STAGES];

	assign en_s29   = !vld_s29 || out_ready;
	assign en_s28   = !vld_s28 || en_s29;
	assign en_s27   = !vld_s27 || en_s28;
	assign en_s2    = !vld_s2 || core_en[0];
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	// stage 1: squares, quadrant fold into right half plane, heading offset
	logic                   act_s1, orig_s1;
	logic signed [XY_W-1:0] cx_s1, cy_s1;
	logic signed [Z_W-1:0]  cz_s1;
	logic [SQ_W-1:0]        sqx_s1, sqy_s1;
	logic [HD_W-1:0]        hd_s1;

	logic signed [23:0]     in_x, in_y, in_h;
	logic [23:0]            abs_x, abs_y;
	logic signed [XY_W-1:0] ext_x, ext_y, fold_x, fold_y;
	logic signed [Z_W-1:0]  fold_z;
	logic signed [HD_W:0]   hd_sum;

	always_comb begin
		in_x   = in_item.target_x;
		in_y   = in_item.target_y;
		in_h   = in_item.heading_error;
		abs_x  = in_x[23] ? (~in_x + 24'd1) : in_x;
		abs_y  = in_y[23] ? (~in_y + 24'd1) : in_y;
		ext_x  = {{(XY_W-24){in_x[23]}}, in_x};
		ext_y  = {{(XY_W-24){in_y[23]}}, in_y};
		fold_x = in_x[23] ? -ext_x : ext_x;
		fold_y = in_x[23] ? -ext_y : ext_y;
		fold_z = '0;
		if (in_x[23]) begin
			fold_z = in_y[23] ? -$signed(PI_Q60) : $signed(PI_Q60);
		end
		hd_sum = {{(HD_W-23){in_h[23]}}, in_h} + $signed({1'b0, HD_OFF_W[HD_W-1:0]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			act_s1  <= in_item.action;
			orig_s1 <= (in_x == 24'sd0) && (in_y == 24'sd0);
			cx_s1   <= fold_x <<< GUARD_BITS;
			cy_s1   <= fold_y <<< GUARD_BITS;
			cz_s1   <= fold_z;
			sqx_s1  <= {{(SQ_W-24){1'b0}}, abs_x} * {{(SQ_W-24){1'b0}}, abs_x};
			sqy_s1  <= {{(SQ_W-24){1'b0}}, abs_y} * {{(SQ_W-24){1'b0}}, abs_y};
			hd_s1   <= hd_sum[HD_W-1:0];
		end
	end

	// stage 2: radicand sum, core entry
	core_t core_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			core_s2.action  <= act_s1;
			core_s2.origin  <= orig_s1;
			core_s2.cx      <= cx_s1;
			core_s2.cy      <= cy_s1;
			core_s2.cz      <= cz_s1;
			core_s2.sq_rem  <= sqx_s1 + sqy_s1;
			core_s2.sq_root <= '0;
			core_s2.hd_rem  <= hd_s1;
		end
	end

	// core stages: one root digit and one modulo step each, one cordic rotation in each of the first CORDIC_STEPS
	core_t core_sk [CORE_STAGES];

	for (genvar k = 0; k < CORE_STAGES; k++) begin : g_core
		localparam bit DO_CORDIC = (k < CORDIC_STEPS);
		localparam logic [63:0] ATAN_K = atan_q60(k);
		localparam logic [RT_W-1:0] SQ_BIT = {{(RT_W-1){1'b0}}, 1'b1} << (2 * (CORE_STAGES - 1 - k));
		localparam logic [63:0] TP_SH_W = TP_F_W << (CORE_STAGES - 1 - k);
		localparam logic [55:0] TP_SH = TP_SH_W[55:0];

		core_t src, nxt;
		logic  src_vld;

		if (k == 0) begin : g_first
			assign src     = core_s2;
			assign src_vld = vld_s2;
		end else begin : g_next
			assign src     = core_sk[k-1];
			assign src_vld = core_vld_sk[k-1];
		end

		if (k == CORE_STAGES - 1) begin : g_last_en
			assign core_en[k] = !core_vld_sk[k] || en_s27;
		end else begin : g_mid_en
			assign core_en[k] = !core_vld_sk[k] || core_en[k+1];
		end

		// stage datapath
		always_comb begin
			logic signed [XY_W-1:0] x_in, y_in, dx, dy;
			logic signed [Z_W-1:0]  z_in;
			logic [RT_W-1:0]        trial;
			x_in  = src.cx;
			y_in  = src.cy;
			z_in  = src.cz;
			dx    = y_in >>> k;
			dy    = x_in >>> k;
			trial = src.sq_root + SQ_BIT;
			nxt   = src;
			if (DO_CORDIC) begin
				if (!y_in[XY_W-1]) begin
					nxt.cx = x_in + dx;
					nxt.cy = y_in - dy;
					nxt.cz = z_in + $signed(ATAN_K);
				end else begin
					nxt.cx = x_in - dx;
					nxt.cy = y_in + dy;
					nxt.cz = z_in - $signed(ATAN_K);
				end
			end
			if ({1'b0, src.sq_rem} >= trial) begin
				nxt.sq_rem  = src.sq_rem - trial[SQ_W-1:0];
				nxt.sq_root = (src.sq_root >> 1) + SQ_BIT;
			end else begin
				nxt.sq_root = src.sq_root >> 1;
			end
			if ({28'd0, src.hd_rem} >= TP_SH) begin
				nxt.hd_rem = src.hd_rem - TP_SH[HD_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				core_vld_sk[k] <= 1'b0;
			end else if (core_en[k]) begin
				core_vld_sk[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (core_en[k]) begin
				core_sk[k] <= nxt;
			end
		end
	end

	// stage 27: angle rounding or heading wrap, speed rounding
	logic signed [AW-1:0] ang_s27;
	logic [24:0]          spd_s27;

	core_t                core_end;
	logic signed [Z_W-1:0] z_rnd;
	logic signed [HD_W:0]  hd_wrap;
	logic [24:0]           spd_pos;
	logic signed [AW-1:0]  ang_nxt;

	always_comb begin
		core_end = core_sk[CORE_STAGES-1];
		z_rnd    = (core_end.cz + Z_HALF) >>> (60 - F);
		hd_wrap  = $signed({1'b0, core_end.hd_rem});
		if (core_end.hd_rem > PI_F) begin
			hd_wrap = $signed({1'b0, core_end.hd_rem}) - $signed({1'b0, TP_F});
		end
		spd_pos = {1'b0, core_end.sq_root[23:0]}
			+ {24'd0, ({1'b0, core_end.sq_rem} > core_end.sq_root)};
		ang_nxt = core_end.origin ? '0 : z_rnd[AW-1:0];
		if (core_end.action == ACT_HEADING) begin
			ang_nxt = hd_wrap[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s27 <= 1'b0;
		end else if (en_s27) begin
			vld_s27 <= core_vld_sk[CORE_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s27) begin
			ang_s27 <= ang_nxt;
			spd_s27 <= (core_end.action == ACT_HEADING) ? 25'd0 : spd_pos;
		end
	end

	// stage 28: turn rate from gain, scaled speed
	logic signed [WW-1:0] turn_s28;
	logic [BW-1:0]        base_s28;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s28 <= 1'b0;
		end else if (en_s28) begin
			vld_s28 <= vld_s27;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s28) begin
			turn_s28 <= $signed({{(WW-12){1'b0}}, turn_gain_q})
				* $signed({{(WW-AW){ang_s27[AW-1]}}, ang_s27});
			base_s28 <= {spd_s27, {S{1'b0}}};
		end
	end

	// stage 29: wheel sums, rounding shift, saturation into the output register
	out_item_t            out_s29;
	logic signed [SW-1:0] sum_r, sum_l, shr_r, shr_l;
	logic signed [SW-1:0] base_sw, turn_sw;
	logic signed [63:0]   ext_r, ext_l;

	always_comb begin
		base_sw = $signed({2'b0, base_s28});
		turn_sw = {{(SW-WW){turn_s28[WW-1]}}, turn_s28};
		sum_r   = base_sw + turn_sw + RND_HALF;
		sum_l   = base_sw - turn_sw + RND_HALF;
		shr_r   = sum_r >>> S;
		shr_l   = sum_l >>> S;
		ext_r   = {{(64-SW){shr_r[SW-1]}}, shr_r};
		ext_l   = {{(64-SW){shr_l[SW-1]}}, shr_l};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s29 <= 1'b0;
		end else if (en_s29) begin
			vld_s29 <= vld_s28;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s29) begin
			out_s29.right_drive <= sat_drive(ext_r);
			out_s29.left_drive  <= sat_drive(ext_l);
		end
	end

	assign out_valid = vld_s29;
	assign out_item  = out_s29;

	// input stalls only behind an occupied first stage
	a_ready_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> vld_s1)
		else $error("in_ready low with first stage empty");

	// square root remainder never exceeds twice the root
	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		core_vld_sk[CORE_STAGES-1] |->
			{2'b0, core_sk[CORE_STAGES-1].sq_rem} <= {core_sk[CORE_STAGES-1].sq_root, 1'b0})
		else $error("square root remainder out of range");

	// heading remainder is fully reduced below two pi
	a_heading_mod: assert property (@(posedge clk) disable iff (!arst_n)
		core_vld_sk[CORE_STAGES-1] |-> core_sk[CORE_STAGES-1].hd_rem < TP_F)
		else $error("heading remainder not reduced");

	// heading requests carry no speed into the multiply stage
	a_heading_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(core_vld_sk[CORE_STAGES-1] && en_s27
			&& core_sk[CORE_STAGES-1].action == ACT_HEADING) |=> spd_s27 == 25'd0)
		else $error("heading request produced nonzero speed");

endmodule
